FILE: rtl/core/potential_field_force_sum_defines.svh
// assertion macros for the potential field force sum block
`ifndef POTENTIAL_FIELD_FORCE_SUM_DEFINES_SVH
`define POTENTIAL_FIELD_FORCE_SUM_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PFFS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pffs assertion failed");
`define PFFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pffs assertion failed");
`else
`define PFFS_ASSERT(lbl, prop)
`define PFFS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/pffs_pkg.sv
// shared types and constants of the potential field force sum block
package pffs_pkg;

	localparam int W = 96;
	localparam int CNT_W = 6;
	localparam int DIV_ITERS = 32;
	localparam int SQRT_ITERS = 35;
	localparam int SQ_ONE_BIT = 68;
	localparam int NEAR_ZERO = 65;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} unit_op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_FIN
	} fsm_t;

	typedef enum logic [3:0] {
		ST_SQX,
		ST_SQY,
		ST_SQZ,
		ST_ROOT,
		ST_UX,
		ST_UY,
		ST_UZ,
		ST_DEN,
		ST_QM,
		ST_KM,
		ST_FX,
		ST_FY,
		ST_FZ
	} step_t;

endpackage

FILE: rtl/core/pffs_unit.sv
// shared bit-serial multiply, divide and square root unit
module pffs_unit import pffs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  unit_op_t     op,
	input  logic [W-1:0] opa,
	input  logic [W-1:0] opb,
	output unit_stat_t   stat,
	output logic [W-1:0] res
);

	localparam logic [W-1:0] SQ_ONE = W'(1) << SQ_ONE_BIT;

	logic             busy_q;
	logic             done_q;
	unit_op_t         op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     acc_q;
	logic [W-1:0]     a_q;
	logic [W-1:0]     b_q;
	logic [W-1:0]     c_q;

	logic [W-1:0] add_sum;
	logic [W-1:0] trial;
	logic         sq_ge;
	logic [W-1:0] sq_diff;
	logic         div_ge;
	logic [W-1:0] div_diff;
	logic         last_iter;

	assign add_sum   = acc_q + a_q;
	assign trial     = c_q + a_q;
	assign sq_ge     = acc_q >= trial;
	assign sq_diff   = acc_q - trial;
	assign div_ge    = acc_q >= a_q;
	assign div_diff  = acc_q - a_q;
	assign last_iter = (op_q == OP_MUL) ? (b_q == '0) : (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				op_q   <= op;
				cnt_q  <= (op == OP_SQRT) ? CNT_W'(SQRT_ITERS - 1) : CNT_W'(DIV_ITERS - 1);
			end else if (busy_q) begin
				if (last_iter) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			case (op)
				OP_MUL: begin
					acc_q <= '0;
					a_q   <= opa;
					b_q   <= opb;
				end
				OP_DIV: begin
					acc_q <= opa;
					a_q   <= opb << (DIV_ITERS - 1);
					b_q   <= '0;
				end
				default: begin
					acc_q <= opa;
					a_q   <= SQ_ONE;
					c_q   <= '0;
				end
			endcase
		end else if (busy_q && !(op_q == OP_MUL && b_q == '0)) begin
			case (op_q)
				OP_MUL: begin
					if (b_q[0]) begin
						acc_q <= add_sum;
					end
					a_q <= a_q << 1;
					b_q <= b_q >> 1;
				end
				OP_DIV: begin
					if (div_ge) begin
						acc_q <= div_diff;
					end
					b_q <= {b_q[W-2:0], div_ge};
					a_q <= a_q >> 1;
				end
				default: begin
					if (sq_ge) begin
						acc_q <= sq_diff;
						c_q   <= (c_q >> 1) + a_q;
					end else begin
						c_q <= c_q >> 1;
					end
					a_q <= a_q >> 2;
				end
			endcase
		end
	end

	always_comb begin
		case (op_q)
			OP_DIV:  res = b_q;
			OP_SQRT: res = c_q;
			default: res = acc_q;
		endcase
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: rtl/core/potential_field_force_sum.sv
// top level of the potential field force sum block
// Takes one object per input transaction on the s_ channel: robot reference
// point, object position, gain and threshold in s_tdata, the repulsive flag
// in s_tuser and the end-of-batch mark in s_tlast. Each object is worked
// through one shared bit-serial unit (multiply, divide, square root) under a
// step sequencer; s_tready is high only while that sequencer is idle.
// An object's time is set by the 35-step square root, the 32-step divisions
// and the shift-add multiplies of the shared unit, whose length follows the
// bit length of the second operand; a repulsive object inside its threshold
// takes longer than an attractive one, and an object too close to the
// reference point leaves after the square root.
// On an object marked last the saturated force sum goes to an output
// register and is offered on the m_ channel as one transaction once the
// sequencer is in its finish state and the output register is free, and the
// sums are cleared. A new object is taken while that result waits; a second
// result waits in the final step until m_tready takes the first.
// Reset clears the sums, the sequencer and m_tvalid.
`include "potential_field_force_sum_defines.svh"

module potential_field_force_sum import pffs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [255:0] s_tdata,  // ref_x, ref_y, ref_z, obj_x, obj_y, obj_z, field_gain,
	                               // threshold_dist, zero pad
	input  logic         s_tuser,  // is_repulsive
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata   // force_x, force_y, force_z
);

	fsm_t  state_q, state_d;
	step_t step_q, step_d;

	logic signed [32:0] v_q [3];
	logic signed [31:0] gain_q;
	logic [30:0]        th_q;
	logic               rep_q;
	logic               last_q;
	logic [65:0]        sumsq_q;
	logic [32:0]        d_q;
	logic [30:0]        umag_q [3];
	logic [61:0]        den_q;
	logic [31:0]        qm_q;
	logic [41:0]        c_mag_q;
	logic               c_neg_q;
	logic signed [47:0] acc_q [3];
	logic               m_tvalid_q;
	logic [95:0]        m_tdata_q;

	logic         start;
	unit_op_t     op;
	logic [W-1:0] opa;
	logic [W-1:0] opb;
	unit_stat_t   stat;
	logic [W-1:0] res;

	logic [1:0]         idx;
	logic [32:0]        vmag;
	logic [31:0]        gmag;
	logic [74:0]        rnd;
	logic [41:0]        mterm;
	logic               tneg;
	logic signed [42:0] term;
	logic signed [48:0] sum49;
	logic signed [47:0] acc_new;
	logic [57:0]        km_rnd;
	logic               out_free;
	logic               emit;
	logic [31:0]        sat [3];

	pffs_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.opa    (opa),
		.opb    (opb),
		.stat   (stat),
		.res    (res)
	);

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign emit     = (state_q == S_FIN) && last_q && out_free;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		case (step_q)
			ST_SQY, ST_UY, ST_FY: idx = 2'd1;
			ST_SQZ, ST_UZ, ST_FZ: idx = 2'd2;
			default:              idx = 2'd0;
		endcase
		vmag = v_q[idx][32] ? 33'(-v_q[idx]) : 33'(v_q[idx]);
		gmag = gain_q[31] ? 32'(-gain_q) : 32'(gain_q);
		rnd     = res[74:0] + {45'd0, 1'b1, 29'd0};
		mterm   = rnd[71:30];
		tneg    = c_neg_q ^ v_q[idx][32];
		term    = tneg ? -$signed({1'b0, mterm}) : $signed({1'b0, mterm});
		sum49   = {acc_q[idx][47], acc_q[idx]} + {{6{term[42]}}, term};
		if (sum49[48] != sum49[47]) begin
			acc_new = sum49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			acc_new = sum49[47:0];
		end
		km_rnd = res[57:0] + {42'd0, 1'b1, 15'd0};
		for (int i = 0; i < 3; i++) begin
			if (acc_q[i][47:31] != {17{acc_q[i][47]}}) begin
				sat[i] = acc_q[i][47] ? 32'h8000_0000 : 32'h7fff_ffff;
			end else begin
				sat[i] = acc_q[i][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_SQX;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		start   = 1'b0;
		op      = OP_MUL;
		opa     = '0;
		opb     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_ISSUE;
					step_d  = ST_SQX;
				end
			end
			S_ISSUE: begin
				start   = 1'b1;
				state_d = S_WAIT;
				case (step_q)
					ST_SQX, ST_SQY, ST_SQZ: begin
						op  = OP_MUL;
						opa = W'(vmag);
						opb = W'(vmag);
					end
					ST_ROOT: begin
						op  = OP_SQRT;
						opa = W'(sumsq_q);
					end
					ST_UX, ST_UY, ST_UZ: begin
						op  = OP_DIV;
						opa = W'(vmag) << 30;
						opb = W'(d_q);
					end
					ST_DEN: begin
						op  = OP_MUL;
						opa = W'(th_q);
						opb = W'(d_q);
					end
					ST_QM: begin
						op  = OP_DIV;
						opa = (W'(th_q) - W'(d_q)) << 32;
						opb = W'(den_q);
					end
					ST_KM: begin
						op  = OP_MUL;
						opa = W'(gmag);
						opb = W'(qm_q);
					end
					default: begin
						op  = OP_MUL;
						opa = W'(c_mag_q);
						opb = W'(umag_q[idx]);
					end
				endcase
			end
			S_WAIT: begin
				if (stat.done) begin
					state_d = S_ISSUE;
					case (step_q)
						ST_SQX: step_d = ST_SQY;
						ST_SQY: step_d = ST_SQZ;
						ST_SQZ: step_d = ST_ROOT;
						ST_ROOT: begin
							if (res <= W'(NEAR_ZERO)) begin
								state_d = S_FIN;
							end else begin
								step_d = ST_UX;
							end
						end
						ST_UX: step_d = ST_UY;
						ST_UY: step_d = ST_UZ;
						ST_UZ: begin
							if (!rep_q) begin
								step_d = ST_FX;
							end else if (d_q >= {2'b00, th_q}) begin
								state_d = S_FIN;
							end else begin
								step_d = ST_DEN;
							end
						end
						ST_DEN: step_d = ST_QM;
						ST_QM:  step_d = ST_KM;
						ST_KM:  step_d = ST_FX;
						ST_FX:  step_d = ST_FY;
						ST_FY:  step_d = ST_FZ;
						default: state_d = S_FIN;
					endcase
				end
			end
			default: begin
				if (!last_q || out_free) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			v_q[0]  <= $signed({s_tdata[127], s_tdata[127:96]})
			           - $signed({s_tdata[31], s_tdata[31:0]});
			v_q[1]  <= $signed({s_tdata[159], s_tdata[159:128]})
			           - $signed({s_tdata[63], s_tdata[63:32]});
			v_q[2]  <= $signed({s_tdata[191], s_tdata[191:160]})
			           - $signed({s_tdata[95], s_tdata[95:64]});
			gain_q  <= s_tdata[223:192];
			th_q    <= s_tdata[254:224];
			rep_q   <= s_tuser;
			last_q  <= s_tlast;
			sumsq_q <= '0;
		end
		if (state_q == S_WAIT && stat.done) begin
			case (step_q)
				ST_SQX, ST_SQY, ST_SQZ: sumsq_q <= sumsq_q + res[65:0];
				ST_ROOT: d_q <= res[32:0];
				ST_UX, ST_UY: umag_q[idx] <= res[30:0];
				ST_UZ: begin
					umag_q[idx] <= res[30:0];
					c_mag_q     <= {10'd0, gmag};
					c_neg_q     <= gain_q[31];
				end
				ST_DEN: den_q <= res[61:0];
				ST_QM:  qm_q  <= res[31:0];
				ST_KM: begin
					c_mag_q <= km_rnd[57:16];
					c_neg_q <= !gain_q[31];
				end
				default: ;
			endcase
		end
		if (emit) begin
			m_tdata_q <= {sat[2], sat[1], sat[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= '0;
			end
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_WAIT && stat.done
			    && (step_q == ST_FX || step_q == ST_FY || step_q == ST_FZ)) begin
				acc_q[idx] <= acc_new;
			end
			if (emit) begin
				for (int i = 0; i < 3; i++) begin
					acc_q[i] <= '0;
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	`PFFS_ASSERT(a_unit_idle_when_ready, s_tready |-> !stat.busy)
	`PFFS_ASSERT(a_done_only_waiting, stat.done |-> state_q == S_WAIT)
	`PFFS_ASSERT_NEXT(a_issue_starts_unit, state_q == S_ISSUE, stat.busy)
	`PFFS_ASSERT(a_result_from_last, $rose(m_tvalid) |-> $past(state_q == S_FIN && last_q))

endmodule

FILE: tb/tb_top.sv
// self-checking testbench of the potential field force sum block
`timescale 1ns / 100ps

module tb_top import pffs_pkg::*;;

	typedef struct {
		logic signed [31:0] ref_x, ref_y, ref_z;
		logic signed [31:0] obj_x, obj_y, obj_z;
		logic signed [31:0] gain;
		logic [30:0]        th;
		logic               rep;
		logic               last;
	} object_t;

	typedef struct {
		logic signed [31:0] fx, fy, fz;
	} force_t;

	localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [255:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;

	object_t pending_objects[$];
	force_t  expected_forces[$];
	object_t cur_obj;
	longint  sum_x, sum_y, sum_z;
	int      burst_left, gap_left, stall_mode, stall_cycles;
	int      errors, objects_sent, forces_seen, skipped_seen, outside_seen, sat_seen;

	potential_field_force_sum dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic longint sat_add48(longint a, longint t);
		longint s;
		s = a + t;
		if (s > ACC_MAX) return ACC_MAX;
		if (s < ACC_MIN) return ACC_MIN;
		return s;
	endfunction

	function automatic logic signed [31:0] clamp32(longint a);
		if (a > 64'sd2147483647) begin
			sat_seen++;
			return 32'sh7FFF_FFFF;
		end
		if (a < -64'sd2147483648) begin
			sat_seen++;
			return 32'sh8000_0000;
		end
		return a[31:0];
	endfunction

	// round(c * u / 2^30) half away from zero, kept to 48 bits of magnitude
	function automatic longint scaled_component(longint c, longint u);
		logic [127:0] p;
		logic [63:0]  mc, mu;
		longint       m;
		mc = (c < 0) ? -c : c;
		mu = (u < 0) ? -u : u;
		p = {64'b0, mc} * {64'b0, mu} + (128'd1 << 29);
		m = longint'((p >> 30) & 128'hFFFF_FFFF_FFFF);
		return ((c < 0) != (u < 0)) ? -m : m;
	endfunction

	function automatic void add_object_force(object_t o);
		longint       v[3], u[3];
		logic [69:0]  sumsq, tt;
		logic [63:0]  d, t, mv, qm, km, thv;
		longint       c;
		logic         use_it;
		v[0] = longint'(o.obj_x) - longint'(o.ref_x);
		v[1] = longint'(o.obj_y) - longint'(o.ref_y);
		v[2] = longint'(o.obj_z) - longint'(o.ref_z);
		sumsq = '0;
		for (int i = 0; i < 3; i++) begin
			mv = (v[i] < 0) ? -v[i] : v[i];
			sumsq += {6'b0, mv} * {6'b0, mv};
		end
		d = 0;
		for (int b = 34; b >= 0; b--) begin
			t = d | (64'd1 << b);
			tt = {6'b0, t} * {6'b0, t};
			if (tt <= sumsq)
				d = t;
		end
		if (d <= NEAR_ZERO) begin
			skipped_seen++;
			return;
		end
		for (int i = 0; i < 3; i++) begin
			mv = (v[i] < 0) ? -v[i] : v[i];
			qm = (mv << 30) / d;
			u[i] = (v[i] < 0) ? -longint'(qm) : longint'(qm);
		end
		c = o.gain;
		use_it = 1'b1;
		thv = {33'b0, o.th};
		if (o.rep) begin
			if (d < thv) begin
				qm = ((thv - d) << 32) / (thv * d);
				mv = (o.gain < 0) ? -longint'(o.gain) : longint'(o.gain);
				km = (mv * qm + (64'd1 << 15)) >> 16;
				c = (o.gain < 0) ? longint'(km) : -longint'(km);
			end else begin
				use_it = 1'b0;
				outside_seen++;
			end
		end
		if (use_it) begin
			sum_x = sat_add48(sum_x, scaled_component(c, u[0]));
			sum_y = sat_add48(sum_y, scaled_component(c, u[1]));
			sum_z = sat_add48(sum_z, scaled_component(c, u[2]));
		end
	endfunction

	function automatic void predict_object(object_t o);
		force_t f;
		add_object_force(o);
		if (o.last) begin
			f.fx = clamp32(sum_x);
			f.fy = clamp32(sum_y);
			f.fz = clamp32(sum_z);
			expected_forces.push_back(f);
			sum_x = 0;
			sum_y = 0;
			sum_z = 0;
		end
	endfunction

	task automatic queue_object(logic signed [31:0] rx, ry, rz, ox, oy, oz, g,
			logic [30:0] th, logic rep, logic last);
		object_t o;
		o.ref_x = rx; o.ref_y = ry; o.ref_z = rz;
		o.obj_x = ox; o.obj_y = oy; o.obj_z = oz;
		o.gain = g; o.th = th; o.rep = rep; o.last = last;
		pending_objects.push_back(o);
	endtask

	function automatic logic signed [31:0] rand_coord(int spread);
		case (spread)
			0: return $urandom_range(0, 2000) - 1000;
			1: return $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_random_object(logic last, int spread, logic close_rep);
		object_t o;
		logic signed [31:0] off;
		o.ref_x = rand_coord(spread); o.ref_y = rand_coord(spread);
		o.ref_z = rand_coord(spread);
		if (close_rep) begin
			off = $urandom_range(100, 5000);
			o.obj_x = o.ref_x + off; o.obj_y = o.ref_y; o.obj_z = o.ref_z;
			o.gain = 32'sh7FFF_FFFF;
			o.th = 31'h7FFF_FFFF;
			o.rep = 1'b1;
		end else begin
			o.obj_x = rand_coord(spread); o.obj_y = rand_coord(spread);
			o.obj_z = rand_coord(spread);
			o.gain = ($urandom_range(0, 3) == 0) ? $urandom
				: $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			o.th = ($urandom_range(0, 3) == 0) ? 31'($urandom)
				: 31'($urandom_range(0, 32'h0010_0000));
			o.rep = 1'($urandom_range(0, 1));
		end
		o.last = last;
		pending_objects.push_back(o);
	endtask

	// driver: bursts of transactions separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			burst_left <= 1;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_object(cur_obj);
				objects_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_objects.size() > 0) begin
					cur_obj = pending_objects.pop_front();
					s_tdata <= {1'b0, cur_obj.th, cur_obj.gain, cur_obj.obj_z, cur_obj.obj_y,
						cur_obj.obj_x, cur_obj.ref_z, cur_obj.ref_y, cur_obj.ref_x};
					s_tuser <= cur_obj.rep;
					s_tlast <= cur_obj.last;
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 8);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: receiver stalls in phases of its own
	always @(posedge clk or negedge arst_n) begin
		force_t e, a;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode <= 0;
			stall_cycles <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				a.fx = m_tdata[31:0];
				a.fy = m_tdata[63:32];
				a.fz = m_tdata[95:64];
				forces_seen++;
				if (expected_forces.size() == 0) begin
					$display("%0t: unexpected force x=%0d y=%0d z=%0d", $time, a.fx, a.fy, a.fz);
					errors++;
				end else begin
					e = expected_forces.pop_front();
					if (a.fx !== e.fx) begin
						$display("%0t: force_x expected %0d actual %0d", $time, e.fx, a.fx);
						errors++;
					end
					if (a.fy !== e.fy) begin
						$display("%0t: force_y expected %0d actual %0d", $time, e.fy, a.fy);
						errors++;
					end
					if (a.fz !== e.fz) begin
						$display("%0t: force_z expected %0d actual %0d", $time, e.fz, a.fz);
						errors++;
					end
				end
			end
			if (stall_cycles == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_cycles <= $urandom_range(200, 3000);
			end else begin
				stall_cycles <= stall_cycles - 1;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 400) == 0);
			endcase
		end
	end

	initial begin
		int n, len, spread;
		errors = 0; objects_sent = 0; forces_seen = 0;
		skipped_seen = 0; outside_seen = 0; sat_seen = 0;
		sum_x = 0; sum_y = 0; sum_z = 0;

		// object on the reference point, skipped, and it closes the batch
		queue_object(100, 200, 300, 100, 200, 300, 32'sh0001_0000, 31'h10000, 1'b0, 1'b1);
		// just inside and just outside the near-zero distance
		queue_object(0, 0, 0, 65, 0, 0, 32'sh0001_0000, 31'h10000, 1'b0, 1'b0);
		queue_object(0, 0, 0, 0, 66, 0, 32'sh0001_0000, 31'h10000, 1'b0, 1'b1);
		// extreme coordinates and gains
		queue_object(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0, 1'b0);
		queue_object(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 31'h7FFF_FFFF, 1'b0, 1'b1);
		// repulsive inside, outside and with zero threshold
		queue_object(0, 0, 0, 32'sh0000_8000, 32'sh0000_4000, 0,
			32'sh0002_0000, 31'h0002_0000, 1'b1, 1'b0);
		queue_object(0, 0, 0, 32'sh0003_0000, 0, 0, 32'sh0002_0000, 31'h0002_0000, 1'b1, 1'b0);
		queue_object(0, 0, 0, 0, 0, 32'sh0000_1000, 32'sh0002_0000, 31'h0, 1'b1, 1'b1);
		queue_object(0, 0, 0, 0, 32'shFFFF_F000, 0, 32'sh8000_0000, 31'h7FFF_FFFF, 1'b1, 1'b1);
		// huge repulsive push saturates the emitted force
		queue_object(0, 0, 0, 100, 0, 0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0);
		queue_object(0, 0, 0, 0, -100, 0, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1);

		n = 0;
		while (n < 800) begin
			len = $urandom_range(1, 8);
			spread = $urandom_range(0, 2);
			if ($urandom_range(0, 60) == 0) begin
				// long close repulsive batch drives the sums past the 32-bit output range
				for (int i = 0; i < 70; i++)
					queue_random_object(i == 69, spread, 1'b1);
				n += 70;
			end else begin
				for (int i = 0; i < len; i++)
					queue_random_object(i == len - 1, spread, 1'b0);
				n += len;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_objects.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_forces.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		$display("%0d objects sent, %0d forces checked", objects_sent, forces_seen);
		$display("%0d skipped near zero, %0d repulsive out of range, %0d clamped components",
			skipped_seen, outside_seen, sat_seen);
		if (errors == 0 && expected_forces.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("timeout with %0d forces outstanding", expected_forces.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
